// ===== rtl/core/bbe_pkg.sv =====
// shared types, constants and arithmetic helpers of the 3x3 box blur core
package bbe_pkg;

  localparam int MaxWidthDefault = 1024;

  localparam int FrameWidthW  = 11;
  localparam int FrameHeightW = 16;
  localparam int CfgDataW     = 16;

  localparam logic [FrameWidthW-1:0]  FrameWidthReset  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightReset = 16'd480;

  localparam int ChanW = 8;
  localparam int SumW  = 12;

  // reciprocals for the divide by 6 and by 9, scaled by 2^RecipShift
  localparam int RecipW     = 14;
  localparam int ProdW      = SumW + RecipW;
  localparam int RecipShift = 16;
  localparam int Recip6     = 10923;
  localparam int Recip9     = 7282;

  // output buffer, a power of two
  localparam int OutDepth = 8;
  localparam int OutCntW  = $clog2(OutDepth + 1);
  localparam int OutPtrW  = $clog2(OutDepth);

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_e;

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][ChanW-1:0] pixel_t;

  // [column][row], column 2 and row 2 newest
  typedef logic [2:0][2:0][2:0][ChanW-1:0] window_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  function automatic logic [SumW-1:0] window_sum(window_t win, logic [2:0] col_mask,
                                                 logic [2:0] row_mask, logic [1:0] ch);
    logic [SumW-1:0] acc;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_mask[c] && row_mask[r]) begin
          acc = acc + SumW'(win[c][r][ch]);
        end
      end
    end
    return acc;
  endfunction

  // (sum + n/2) / n for n of 4, 6 or 9
  function automatic logic [ChanW-1:0] div_round(logic [SumW-1:0] sum, div_e n);
    logic [SumW-1:0]  biased;
    logic [ProdW-1:0] prod;
    logic [ChanW-1:0] q;
    biased = sum;
    prod   = '0;
    q      = '0;
    unique case (n)
      DIV_4: begin
        biased = sum + SumW'(2);
        q      = biased[2 +: ChanW];
      end
      DIV_6: begin
        biased = sum + SumW'(3);
        prod   = ProdW'(biased) * ProdW'(Recip6);
        q      = prod[RecipShift +: ChanW];
      end
      DIV_9: begin
        biased = sum + SumW'(4);
        prod   = ProdW'(biased) * ProdW'(Recip9);
        q      = prod[RecipShift +: ChanW];
      end
      default: begin
        q = '0;
      end
    endcase
    return q;
  endfunction

endpackage

// ===== rtl/core/bbe_pix_if.sv =====
// input channel: operation and incoming pixel
interface bbe_pix_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [bbe_pkg::ChanW-1:0] in_red;
  logic [bbe_pkg::ChanW-1:0] in_green;
  logic [bbe_pkg::ChanW-1:0] in_blue;

  modport source (output valid, output operation, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink (input valid, input operation, input in_red, input in_green,
                input in_blue, output ready);
endinterface

// ===== rtl/core/bbe_res_if.sv =====
// output channel: blurred pixel and end of frame flag
interface bbe_res_if;
  logic                      valid;
  logic                      ready;
  logic [bbe_pkg::ChanW-1:0] out_red;
  logic [bbe_pkg::ChanW-1:0] out_green;
  logic [bbe_pkg::ChanW-1:0] out_blue;
  logic                      frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input frame_last, output ready);
endinterface

// ===== rtl/core/box_blur_3x3_edge_clipped_core.sv =====
// top level of the 3x3 edge clipped box blur on a raster stream of RGB pixels
// in_i takes one word per pixel (operation = pixel) in raster order; once the
// last row is in, the frame is finished by one drain word per column, and the
// drain word of the last column gives the output that carries frame_last.
// out_o gives the blurred pixels in raster order: none for row 0, one per
// pixel from column 1 on, and two for the last column of a row.
// frame_width and frame_height are written through cfg_we_i / cfg_index_i /
// cfg_wdata_i; the user must write them only while the core is idle, as the
// core does not enforce it; a write also restarts the frame. One input word
// per cycle is taken while in_i.ready is high; the line memory is read at
// accept and written back from stage 1. An output passes stage 1 and stage 2
// and an 8 word output buffer, which also holds the extra output at a row end.
// When the receiver stalls the buffer fills, and in_i.ready drops once fewer
// than two words of room would remain for the words still in the pipeline.
// Reset clears the counters and the output buffer and loads 640 x 480; the
// line memory needs no clearing, as a row is written before it is read.
module box_blur_3x3_edge_clipped_core #(
  parameter int MAX_WIDTH = bbe_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  bbe_pkg::cfg_idx_e              cfg_index_i,
  input  logic [bbe_pkg::CfgDataW-1:0]   cfg_wdata_i,
  bbe_pix_if.sink                        in_i,
  bbe_res_if.source                      out_o
);
  import bbe_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WideW = (FrameWidthW > ColW + 1) ? FrameWidthW : ColW + 1;
  localparam int NeedW = OutCntW + 2;

  typedef struct packed {
    op_e             op;
    pixel_t          px;
    logic [ColW-1:0] addr;
    logic            r_ge1;
    logic            r_ge2;
    logic            c_ge1;
    logic            c_ge2;
    logic            c_last;
    logic            d_first;
    logic            d_last;
  } s1_t;

  typedef struct packed {
    logic [2:0][SumW-1:0] sum0;
    logic [2:0][SumW-1:0] sum1;
    div_e                 n0;
    div_e                 n1;
    logic                 has1;
    logic                 last;
  } s2_t;

  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic [ColW-1:0]         col_q;
  logic [FrameHeightW-1:0] row_q;
  logic [ColW-1:0]         drain_q;

  logic [WideW-1:0]        fw_wide;
  logic [WideW-1:0]        w_eff;
  logic [ColW-1:0]         last_col;
  logic [FrameHeightW-1:0] h_eff;

  logic in_accept;
  logic draining;
  logic pix_work;
  logic drain_work;

  logic            mem_re;
  logic [ColW-1:0] mem_raddr_a;
  logic            mem_we;
  line_t           mem_wdata;
  line_t           rd_a;
  line_t           rd_b;

  logic    s1_valid_q;
  s1_t     s1_q, s1_d;
  window_t win_q, win_d;

  logic [2:0]           col_mask0;
  logic [2:0]           row_mask;
  div_e                 n0, n1;
  logic                 has0, has1, res_last;
  logic [2:0][SumW-1:0] sum0, sum1;

  logic  s2_valid_q;
  s2_t   s2_q;
  push_t push;

  logic [OutCntW-1:0] buf_count;
  logic [NeedW-1:0]   need;

  // effective frame size
  always_comb begin
    fw_wide = WideW'(frame_width_q);
    if (fw_wide < WideW'(2)) begin
      w_eff = WideW'(2);
    end else if (fw_wide > WideW'(MAX_WIDTH)) begin
      w_eff = WideW'(MAX_WIDTH);
    end else begin
      w_eff = fw_wide;
    end
    last_col = ColW'(w_eff - WideW'(1));
    h_eff    = (frame_height_q < FrameHeightW'(2)) ? FrameHeightW'(2) : frame_height_q;
  end

  assign need = NeedW'(buf_count) + NeedW'({s1_valid_q, 1'b0})
              + NeedW'({s2_valid_q, 1'b0}) + NeedW'(2);
  assign in_i.ready = (need <= NeedW'(OutDepth));

  assign in_accept  = in_i.valid && in_i.ready;
  assign draining   = (row_q >= h_eff);
  assign pix_work   = in_accept && (op_e'(in_i.operation) == OP_PIXEL) && !draining;
  assign drain_work = in_accept && (op_e'(in_i.operation) == OP_DRAIN) && draining;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
      col_q          <= '0;
      row_q          <= '0;
      drain_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FrameWidthW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FrameHeightW-1:0];
      endcase
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else if (pix_work) begin
      if (col_q == last_col) begin
        col_q <= '0;
        row_q <= row_q + FrameHeightW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
      drain_q <= '0;
    end else if (drain_work) begin
      if (drain_q == last_col) begin
        col_q   <= '0;
        row_q   <= '0;
        drain_q <= '0;
      end else begin
        drain_q <= drain_q + ColW'(1);
      end
    end
  end

  // read at accept; a drain word reads the column right of its own
  assign mem_re      = pix_work || drain_work;
  assign mem_raddr_a = pix_work ? col_q : (drain_q + ColW'(1));

  always_comb begin
    s1_d         = '0;
    s1_d.op      = op_e'(in_i.operation);
    s1_d.px      = {in_i.in_red, in_i.in_green, in_i.in_blue};
    s1_d.addr    = col_q;
    s1_d.r_ge1   = (row_q != '0);
    s1_d.r_ge2   = (row_q >= FrameHeightW'(2));
    s1_d.c_ge1   = (col_q != '0);
    s1_d.c_ge2   = (WideW'(col_q) >= WideW'(2));
    s1_d.c_last  = (col_q == last_col);
    s1_d.d_first = (drain_q == '0);
    s1_d.d_last  = (drain_q == last_col);
  end

  bbe_line_mem #(
    .Depth (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (s1_q.addr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i ('0),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // stage 1: window update, line write-back, channel sums
  always_comb begin
    win_d           = win_q;
    mem_we          = 1'b0;
    mem_wdata.older = rd_a.newer;
    mem_wdata.newer = s1_q.px;
    col_mask0       = 3'b110;
    row_mask        = 3'b110;
    n0              = DIV_4;
    n1              = DIV_4;
    has0            = 1'b0;
    has1            = 1'b0;
    res_last        = 1'b0;
    if (s1_valid_q) begin
      if (s1_q.op == OP_PIXEL) begin
        mem_we      = 1'b1;
        win_d[0]    = win_q[1];
        win_d[1]    = win_q[2];
        win_d[2][0] = rd_a.older;
        win_d[2][1] = rd_a.newer;
        win_d[2][2] = s1_q.px;
        row_mask    = s1_q.r_ge2 ? 3'b111 : 3'b110;
        col_mask0   = s1_q.c_ge2 ? 3'b111 : 3'b110;
        n0          = (s1_q.r_ge2 && s1_q.c_ge2) ? DIV_9 :
                      ((s1_q.r_ge2 || s1_q.c_ge2) ? DIV_6 : DIV_4);
        n1          = s1_q.r_ge2 ? DIV_6 : DIV_4;
        has0        = s1_q.r_ge1 && s1_q.c_ge1;
        has1        = s1_q.r_ge1 && s1_q.c_ge1 && s1_q.c_last;
      end else begin
        has0     = 1'b1;
        res_last = s1_q.d_last;
        priority if (s1_q.d_first) begin
          win_d[1][1] = rd_b.older;
          win_d[1][2] = rd_b.newer;
          win_d[2][1] = rd_a.older;
          win_d[2][2] = rd_a.newer;
        end else if (s1_q.d_last) begin
          win_d = win_q;
        end else begin
          win_d[0]    = win_q[1];
          win_d[1]    = win_q[2];
          win_d[2][1] = rd_a.older;
          win_d[2][2] = rd_a.newer;
          col_mask0   = 3'b111;
          n0          = DIV_6;
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum0[ch] = window_sum(win_d, col_mask0, row_mask, 2'(ch));
      sum1[ch] = window_sum(win_d, 3'b110, row_mask, 2'(ch));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
    win_q     <= win_d;
    s2_q.sum0 <= sum0;
    s2_q.sum1 <= sum1;
    s2_q.n0   <= n0;
    s2_q.n1   <= n1;
    s2_q.has1 <= has1;
    s2_q.last <= res_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_work || drain_work;
      s2_valid_q <= has0;
    end
  end

  // stage 2: rounded divide, push into the output buffer
  always_comb begin
    push.push0      = s2_valid_q;
    push.push1      = s2_valid_q && s2_q.has1;
    push.res0.red   = div_round(s2_q.sum0[2], s2_q.n0);
    push.res0.green = div_round(s2_q.sum0[1], s2_q.n0);
    push.res0.blue  = div_round(s2_q.sum0[0], s2_q.n0);
    push.res0.last  = s2_q.last;
    push.res1.red   = div_round(s2_q.sum1[2], s2_q.n1);
    push.res1.green = div_round(s2_q.sum1[1], s2_q.n1);
    push.res1.blue  = div_round(s2_q.sum1[0], s2_q.n1);
    push.res1.last  = 1'b0;
  end

  bbe_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .out_o   (out_o),
    .count_o (buf_count)
  );

`ifndef SYNTHESIS
  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(s1_valid_q))
    else $error("stage 2 word without a stage 1 word before it");

  a_work_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_work || drain_work) |=> s1_valid_q)
    else $error("accepted pixel or drain word did not reach stage 1");

  a_buf_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_count <= OutCntW'(OutDepth))
    else $error("output buffer overflow");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_work && (drain_q == last_col)) |=> (row_q == '0 && drain_q == '0))
    else $error("counters not restarted after the last drain word");

  a_drain_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.last) |-> !s2_q.has1)
    else $error("frame end word paired with a second output");
`endif

endmodule

// ===== rtl/core/bbe_line_mem.sv =====
// line memory holding the two previous rows, one write and two registered reads
module bbe_line_mem #(
  parameter int Depth = bbe_pkg::MaxWidthDefault,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  bbe_pkg::line_t      wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_a_i,
  input  logic [AddrW-1:0]    raddr_b_i,
  output bbe_pkg::line_t      rdata_a_o,
  output bbe_pkg::line_t      rdata_b_o
);
  import bbe_pkg::*;

  line_t mem_q [Depth];
  line_t rdata_a_q;
  line_t rdata_b_q;

  // write-first on a same address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/core/bbe_out_buf.sv =====
// output buffer taking up to two words a cycle and sending one while out_o.ready is high
module bbe_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbe_pkg::push_t                push_i,
  bbe_res_if.source                     out_o,
  output logic [bbe_pkg::OutCntW-1:0]   count_o
);
  import bbe_pkg::*;

  result_t              slot_q [OutDepth];
  logic [OutPtrW-1:0]   wr_q, wr_d;
  logic [OutPtrW-1:0]   rd_q, rd_d;
  logic [OutCntW-1:0]   cnt_q, cnt_d;
  logic                 pop;
  result_t              head;

  assign head          = slot_q[rd_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_red    = head.red;
  assign out_o.out_green  = head.green;
  assign out_o.out_blue   = head.blue;
  assign out_o.frame_last = head.last;
  assign pop           = out_o.valid && out_o.ready;
  assign count_o       = cnt_q;

  always_comb begin
    wr_d  = wr_q + OutPtrW'(push_i.push0) + OutPtrW'(push_i.push1);
    rd_d  = rd_q + OutPtrW'(pop);
    cnt_d = cnt_q + OutCntW'(push_i.push0) + OutCntW'(push_i.push1) - OutCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      slot_q[wr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      slot_q[wr_q + OutPtrW'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
